@@ sv/srat_pkg.sv @@
// ---------------------------------------------------------------------------
// srat_pkg
// Opcodes, status codes and field widths for the reservation accounting table.
// ---------------------------------------------------------------------------
`default_nettype none
package srat_pkg;
    localparam int TASK_BITS = 32;
    localparam int KIND_BITS = 2;
    localparam int CNT_BITS  = 32;

    typedef enum logic [2:0] {
        OP_ALLOC    = 3'd0,
        OP_RESERVE  = 3'd1,
        OP_COMMIT   = 3'd2,
        OP_REL_RES  = 3'd3,
        OP_RELEASE  = 3'd4,
        OP_MERGE    = 3'd5,
        OP_REL_TASK = 3'd6,
        OP_LOOKUP   = 3'd7
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_SPACE = 3'd1,
        ST_REJECT   = 3'd2,
        ST_ZERO_TSK = 3'd3,
        ST_EXHAUST  = 3'd4,
        ST_FAIL_FUL = 3'd5
    } status_t;

    localparam logic [KIND_BITS-1:0] KIND_STATE = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_BATCH = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_INIT  = 2'd2;
endpackage
`default_nettype wire

@@ sv/storage_reservation_accounting_table.sv @@
// ---------------------------------------------------------------------------
// storage_reservation_accounting_table
// Byte accounting over a table of entries with a sequential slot scanner.
// ---------------------------------------------------------------------------
// One item is taken at a time. Every operation walks the entry table one
// slot a cycle through a single read port, merge walks it twice (once per
// handle), and bookkeeping follows in S_EXEC (S_MERGE_CHK too for merge),
// S_LOOK, S_LOOK_RD and S_DONE, which posts the result. The result is held
// in an output register; the next item is taken the cycle after it has
// been handed over. Entry payload lives in a memory; only valid bits are
// flip-flops, cleared by reset.
`default_nettype none
module storage_reservation_accounting_table
    import srat_pkg::*;
#(
    parameter int ENTRIES     = 64,
    parameter int BYTE_BITS   = 48,
    parameter int HANDLE_BITS = 32,
    localparam int IN_RAW  = 3 + TASK_BITS + KIND_BITS + BYTE_BITS + 64,
    localparam int IN_W    = ((IN_RAW + 7) / 8) * 8,
    localparam int OUT_RAW = 3 + 32 + CNT_BITS + TASK_BITS + KIND_BITS + 1 + 6 * BYTE_BITS,
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [BYTE_BITS-1:0] cfg_wr_data,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // opcode[2:0], task_id, kind, byte_count, handle, second_handle, zero pad
    input  wire logic [IN_W-1:0]      s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // status[2:0], new_handle, tally, entry_task, entry_kind, entry_bytes,
    // entry_is_reserved, used, reserved, peak used, peak reserved, peak total
    output logic [OUT_W-1:0]          m_axis_tdata
);
    localparam int IDX_BITS = $clog2(ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_SCAN2, S_EXEC, S_MERGE_CHK, S_LOOK, S_LOOK_RD, S_DONE
    } state_t;

    typedef struct packed {
        logic [HANDLE_BITS-1:0] handle;
        logic [TASK_BITS-1:0]   task_id;
        logic [KIND_BITS-1:0]   kind;
        logic [BYTE_BITS-1:0]   bytes;
        logic                   rsv;
    } rec_t;

    // entry memory, one read and one write port
    rec_t mem [ENTRIES];
    rec_t rd_reg;
    logic [IDX_BITS-1:0] rd_addr;
    logic                wr_en;
    logic [IDX_BITS-1:0] wr_addr;
    rec_t                wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    logic [ENTRIES-1:0] valid_reg;
    state_t state_reg;
    logic [IDX_BITS:0]  cnt_reg;      // issued read address
    logic               rdv_reg;      // rd_reg holds slot rslot_reg
    logic [IDX_BITS-1:0] rslot_reg;
    logic [BYTE_BITS-1:0] cap_reg, used_reg, rsvd_reg, pku_reg, pkr_reg, pkt_reg;
    logic [HANDLE_BITS-1:0] nh_reg;
    logic [CNT_BITS-1:0] fail_reg, count_reg;
    opcode_t op_reg;
    logic [TASK_BITS-1:0] task_reg;
    logic [KIND_BITS-1:0] kind_reg;
    logic [BYTE_BITS-1:0] bytes_reg;
    logic [31:0] h_reg, h2_reg;
    logic fs_reg, fb_reg, ff_reg;     // found handle, found second, found free
    logic [IDX_BITS-1:0] s_reg, b_reg, free_reg;
    rec_t sr_reg, br_reg;
    logic [2:0] st_reg;
    logic [31:0] newh_reg;
    logic [OUT_W-1:0] out_reg;
    logic outv_reg;

    assign s_axis_tready = (state_reg == S_IDLE) && !outv_reg;
    assign m_axis_tvalid = outv_reg;
    assign m_axis_tdata  = out_reg;

    logic [HANDLE_BITS-1:0] key;
    assign key = (state_reg == S_SCAN2) ? HANDLE_BITS'(h2_reg) : HANDLE_BITS'(h_reg);
    logic hit;
    assign hit = rdv_reg && valid_reg[rslot_reg] && (rd_reg.handle == key);
    logic thit;
    assign thit = rdv_reg && valid_reg[rslot_reg] && (rd_reg.task_id == task_reg);

    logic [BYTE_BITS:0] held;
    assign held = {1'b0, used_reg} + {1'b0, rsvd_reg};
    logic [BYTE_BITS:0] freeb;
    assign freeb = ({1'b0, cap_reg} > held) ? ({1'b0, cap_reg} - held) : '0;

    logic [BYTE_BITS:0] msum;
    assign msum = {1'b0, sr_reg.bytes} + {1'b0, br_reg.bytes};

    logic scan_end;
    assign scan_end = rdv_reg && (rslot_reg == IDX_BITS'(ENTRIES - 1));

    logic lk_ok;
    assign lk_ok = fs_reg && valid_reg[s_reg] && (op_reg == OP_COMMIT || op_reg == OP_LOOKUP);

    always_comb
    begin
        rd_addr = cnt_reg[IDX_BITS-1:0];
        if (state_reg == S_LOOK || state_reg == S_LOOK_RD)
        begin
            rd_addr = s_reg;
        end
        wr_en   = 1'b0;
        wr_addr = s_reg;
        wr_data = sr_reg;
        if (state_reg == S_EXEC && (op_reg == OP_ALLOC || op_reg == OP_RESERVE))
        begin
            wr_addr = free_reg;
            wr_data.handle  = nh_reg;
            wr_data.task_id = task_reg;
            wr_data.kind    = kind_reg;
            wr_data.bytes   = bytes_reg;
            wr_data.rsv     = (op_reg == OP_RESERVE);
            wr_en = (task_reg != '0) && ({1'b0, bytes_reg} <= freeb) && (nh_reg != '0)
                    && ff_reg;
        end
        else if (state_reg == S_EXEC && op_reg == OP_COMMIT && fs_reg && sr_reg.rsv)
        begin
            wr_en = 1'b1;
            wr_data.rsv = 1'b0;
        end
        else if (state_reg == S_MERGE_CHK && msum >= {1'b0, bytes_reg})
        begin
            wr_en = 1'b1;
            wr_data.bytes = bytes_reg;
        end
    end

    function automatic logic [BYTE_BITS-1:0] bmax(input logic [BYTE_BITS-1:0] a,
                                                  input logic [BYTE_BITS-1:0] b);
        bmax = (a > b) ? a : b;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            cnt_reg   <= '0;
            rdv_reg   <= 1'b0;
            cap_reg   <= '0;
            used_reg  <= '0;
            rsvd_reg  <= '0;
            pku_reg   <= '0;
            pkr_reg   <= '0;
            pkt_reg   <= '0;
            nh_reg    <= HANDLE_BITS'(1);
            fail_reg  <= '0;
            outv_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            if (outv_reg && m_axis_tready)
            begin
                outv_reg <= 1'b0;
            end
            rdv_reg   <= 1'b0;
            rslot_reg <= cnt_reg[IDX_BITS-1:0];
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        op_reg    <= opcode_t'(s_axis_tdata[2:0]);
                        task_reg  <= s_axis_tdata[3 +: TASK_BITS];
                        kind_reg  <= s_axis_tdata[3 + TASK_BITS +: KIND_BITS];
                        bytes_reg <= s_axis_tdata[3 + TASK_BITS + KIND_BITS +: BYTE_BITS];
                        h_reg     <= s_axis_tdata[3 + TASK_BITS + KIND_BITS + BYTE_BITS +: 32];
                        h2_reg    <= s_axis_tdata[35 + TASK_BITS + KIND_BITS + BYTE_BITS +: 32];
                        fs_reg    <= 1'b0;
                        fb_reg    <= 1'b0;
                        ff_reg    <= 1'b0;
                        count_reg <= '0;
                        st_reg    <= ST_OK;
                        newh_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN, S_SCAN2:
                begin
                    if (cnt_reg <= (IDX_BITS+1)'(ENTRIES - 1))
                    begin
                        rdv_reg <= 1'b1;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (state_reg == S_SCAN && !ff_reg && cnt_reg <= (IDX_BITS+1)'(ENTRIES - 1)
                        && !valid_reg[cnt_reg[IDX_BITS-1:0]])
                    begin
                        ff_reg   <= 1'b1;
                        free_reg <= cnt_reg[IDX_BITS-1:0];
                    end
                    if (state_reg == S_SCAN && op_reg == OP_REL_TASK && thit
                        && task_reg != '0)
                    begin
                        valid_reg[rslot_reg] <= 1'b0;
                        count_reg <= count_reg + 1'b1;
                        if (rd_reg.rsv)
                            rsvd_reg <= rsvd_reg - rd_reg.bytes;
                        else
                            used_reg <= used_reg - rd_reg.bytes;
                    end
                    if (hit && state_reg == S_SCAN && !fs_reg)
                    begin
                        fs_reg <= 1'b1;
                        s_reg  <= rslot_reg;
                        sr_reg <= rd_reg;
                    end
                    if (hit && state_reg == S_SCAN2 && !fb_reg)
                    begin
                        fb_reg <= 1'b1;
                        b_reg  <= rslot_reg;
                        br_reg <= rd_reg;
                    end
                    if (scan_end)
                    begin
                        if (state_reg == S_SCAN && op_reg == OP_MERGE)
                        begin
                            cnt_reg   <= '0;
                            state_reg <= S_SCAN2;
                        end
                        else
                        begin
                            state_reg <= S_EXEC;
                        end
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_LOOK;
                    case (op_reg)
                        OP_ALLOC, OP_RESERVE:
                        begin
                            if (task_reg == '0)
                                st_reg <= ST_ZERO_TSK;
                            else if ({1'b0, bytes_reg} > freeb)
                            begin
                                if (fail_reg == '1)
                                    st_reg <= ST_FAIL_FUL;
                                else
                                begin
                                    fail_reg <= fail_reg + 1'b1;
                                    st_reg   <= ST_NO_SPACE;
                                end
                            end
                            else if (nh_reg == '0 || !ff_reg)
                                st_reg <= ST_EXHAUST;
                            else
                            begin
                                valid_reg[free_reg] <= 1'b1;
                                newh_reg <= 32'(nh_reg);
                                nh_reg   <= nh_reg + 1'b1;
                                if (op_reg == OP_RESERVE)
                                begin
                                    rsvd_reg <= rsvd_reg + bytes_reg;
                                    pkr_reg  <= bmax(pkr_reg, rsvd_reg + bytes_reg);
                                    pku_reg  <= bmax(pku_reg, used_reg);
                                end
                                else
                                begin
                                    used_reg <= used_reg + bytes_reg;
                                    pku_reg  <= bmax(pku_reg, used_reg + bytes_reg);
                                    pkr_reg  <= bmax(pkr_reg, rsvd_reg);
                                end
                                pkt_reg <= bmax(pkt_reg, used_reg + rsvd_reg + bytes_reg);
                            end
                        end
                        OP_COMMIT, OP_REL_RES, OP_RELEASE:
                        begin
                            if (!fs_reg || sr_reg.rsv != (op_reg != OP_RELEASE))
                                st_reg <= ST_REJECT;
                            else if (op_reg == OP_COMMIT)
                            begin
                                rsvd_reg <= rsvd_reg - sr_reg.bytes;
                                used_reg <= used_reg + sr_reg.bytes;
                                pku_reg  <= bmax(pku_reg, used_reg + sr_reg.bytes);
                                pkr_reg  <= bmax(pkr_reg, rsvd_reg - sr_reg.bytes);
                                pkt_reg  <= bmax(pkt_reg, used_reg + rsvd_reg);
                            end
                            else
                            begin
                                valid_reg[s_reg] <= 1'b0;
                                if (op_reg == OP_REL_RES)
                                    rsvd_reg <= rsvd_reg - sr_reg.bytes;
                                else
                                    used_reg <= used_reg - sr_reg.bytes;
                            end
                        end
                        OP_MERGE:
                        begin
                            if (h_reg == h2_reg || !fs_reg || !fb_reg || sr_reg.rsv
                                || br_reg.rsv || sr_reg.task_id != br_reg.task_id
                                || sr_reg.kind != KIND_STATE
                                || (br_reg.kind != KIND_BATCH && br_reg.kind != KIND_INIT))
                                st_reg <= ST_REJECT;
                            else
                                state_reg <= S_MERGE_CHK;
                        end
                        OP_LOOKUP:
                        begin
                            if (!fs_reg)
                                st_reg <= ST_REJECT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_MERGE_CHK:
                begin
                    state_reg <= S_LOOK;
                    if (msum < {1'b0, bytes_reg})
                        st_reg <= ST_REJECT;
                    else
                    begin
                        used_reg <= used_reg - (msum[BYTE_BITS-1:0] - bytes_reg);
                        valid_reg[b_reg] <= 1'b0;
                    end
                end
                S_LOOK:
                begin
                    // read back the entry as it stands after the step
                    state_reg <= S_LOOK_RD;
                end
                S_LOOK_RD:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    outv_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                    out_reg   <= OUT_W'({pkt_reg, pkr_reg, pku_reg, rsvd_reg, used_reg,
                        (lk_ok ? rd_reg.rsv : 1'b0),
                        (lk_ok ? rd_reg.bytes : {BYTE_BITS{1'b0}}),
                        (lk_ok ? rd_reg.kind : {KIND_BITS{1'b0}}),
                        (lk_ok ? rd_reg.task_id : {TASK_BITS{1'b0}}),
                        (op_reg == OP_REL_TASK ? count_reg : fail_reg),
                        newh_reg, st_reg});
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> m_axis_tvalid) else $error("result not posted");
    a_peak: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> (pku_reg >= used_reg || op_reg != OP_COMMIT))
        else $error("peak below used after commit");
`endif
endmodule
`default_nettype wire

@@ tb/storage_reservation_accounting_table_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// storage_reservation_accounting_table_tb
// Directed and randomised stream test of the reservation accounting table. Items come
// from a pending queue and go out in bursts. A shadow table predicts every
// result, and results are checked field by field while the output side
// stalls on a pattern of its own.
// ---------------------------------------------------------------------------
module storage_reservation_accounting_table_tb;
    import srat_pkg::*;

    localparam int NSLOT  = 64;
    localparam int IN_W   = 152;
    localparam int OUT_W  = 392;
    localparam int LIMIT  = 2000000;
    localparam logic [47:0] BMAX = 48'hFFFF_FFFF_FFFF;

    typedef struct {
        opcode_t     op;
        logic [31:0] tsk;
        logic [1:0]  knd;
        logic [47:0] nbytes;
        logic [31:0] h;
        logic [31:0] h2;
    } acct_req_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [47:0]          cfg_wr_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // opcode, task_id, kind, byte_count, handle, second_handle, zero pad
    logic [IN_W-1:0]      s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // status, new_handle, tally, entry_task, entry_kind, entry_bytes,
    // entry_is_reserved, used, reserved, peak used, peak reserved, peak total
    logic [OUT_W-1:0]     m_axis_tdata;

    storage_reservation_accounting_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // shadow of the table
    logic        sh_valid [NSLOT];
    logic [31:0] sh_handle [NSLOT];
    logic [31:0] sh_task [NSLOT];
    logic [1:0]  sh_kind [NSLOT];
    logic [47:0] sh_bytes [NSLOT];
    logic        sh_resv [NSLOT];
    logic [47:0] sh_used, sh_reserved, sh_pk_used, sh_pk_resv, sh_pk_total, sh_cap;
    logic [31:0] sh_next, sh_fails;

    acct_req_t        pend_q[$];
    logic [OUT_W-1:0] result_q[$];
    acct_req_t        cur_req;
    int               errors = 0;
    int               cycles = 0;
    int               n_results = 0;

    localparam int FLD_LO [12] = '{0, 3, 35, 67, 99, 101, 149, 150, 198, 246, 294, 342};
    localparam int FLD_W  [12] = '{3, 32, 32, 32, 2, 48, 1, 48, 48, 48, 48, 48};
    string fld_name [12] = '{"status", "new_handle", "tally", "entry_task", "entry_kind",
        "entry_bytes", "entry_is_reserved", "used", "reserved", "peak_used",
        "peak_reserved", "peak_total"};

    initial
    begin
        for (int i = 0; i < NSLOT; i++)
            sh_valid[i] = 1'b0;
        sh_used = '0; sh_reserved = '0; sh_pk_used = '0; sh_pk_resv = '0;
        sh_pk_total = '0; sh_cap = '0; sh_next = 32'd1; sh_fails = '0;
    end

    function automatic int find_entry(logic [31:0] h);
        for (int i = 0; i < NSLOT; i++)
            if (sh_valid[i] && sh_handle[i] == h)
                return i;
        return -1;
    endfunction

    function automatic void bump_peaks();
        logic [47:0] t;
        t = sh_used + sh_reserved;
        if (sh_used > sh_pk_used) sh_pk_used = sh_used;
        if (sh_reserved > sh_pk_resv) sh_pk_resv = sh_reserved;
        if (t > sh_pk_total) sh_pk_total = t;
    endfunction

    function automatic logic [OUT_W-1:0] account_step(acct_req_t r);
        status_t     st;
        logic [31:0] newh, tally, cnt;
        logic [48:0] held, freeb;
        logic [48:0] sum2;
        logic [31:0] e_task;
        logic [1:0]  e_kind;
        logic [47:0] e_bytes;
        logic        e_resv;
        int          s, b;
        st = ST_OK; newh = '0; cnt = '0;
        e_task = '0; e_kind = '0; e_bytes = '0; e_resv = 1'b0;
        case (r.op)
            OP_ALLOC, OP_RESERVE:
            begin
                held = {1'b0, sh_used} + {1'b0, sh_reserved};
                freeb = ({1'b0, sh_cap} > held) ? {1'b0, sh_cap} - held : '0;
                if (r.tsk == 0)
                    st = ST_ZERO_TSK;
                else if ({1'b0, r.nbytes} > freeb)
                begin
                    if (sh_fails == 32'hFFFF_FFFF)
                        st = ST_FAIL_FUL;
                    else
                    begin
                        sh_fails++;
                        st = ST_NO_SPACE;
                    end
                end
                else
                begin
                    s = -1;
                    for (int i = 0; i < NSLOT; i++)
                        if (!sh_valid[i] && s < 0)
                            s = i;
                    if (sh_next == 0 || s < 0)
                        st = ST_EXHAUST;
                    else
                    begin
                        sh_valid[s] = 1'b1;
                        sh_handle[s] = sh_next;
                        sh_task[s] = r.tsk;
                        sh_kind[s] = r.knd;
                        sh_bytes[s] = r.nbytes;
                        sh_resv[s] = (r.op == OP_RESERVE);
                        newh = sh_next;
                        sh_next = sh_next + 1;
                        if (r.op == OP_RESERVE) sh_reserved += r.nbytes;
                        else sh_used += r.nbytes;
                        bump_peaks();
                    end
                end
            end
            OP_COMMIT, OP_REL_RES, OP_RELEASE:
            begin
                s = find_entry(r.h);
                if (s < 0 || sh_resv[s] != (r.op != OP_RELEASE))
                    st = ST_REJECT;
                else if (r.op == OP_COMMIT)
                begin
                    sh_reserved -= sh_bytes[s];
                    sh_used += sh_bytes[s];
                    sh_resv[s] = 1'b0;
                    bump_peaks();
                end
                else
                begin
                    if (r.op == OP_REL_RES) sh_reserved -= sh_bytes[s];
                    else sh_used -= sh_bytes[s];
                    sh_valid[s] = 1'b0;
                end
            end
            OP_MERGE:
            begin
                s = find_entry(r.h);
                b = find_entry(r.h2);
                if (r.h == r.h2 || s < 0 || b < 0)
                    st = ST_REJECT;
                else if (sh_resv[s] || sh_resv[b] || sh_task[s] != sh_task[b] ||
                         sh_kind[s] != KIND_STATE ||
                         (sh_kind[b] != KIND_BATCH && sh_kind[b] != KIND_INIT))
                    st = ST_REJECT;
                else
                begin
                    sum2 = {1'b0, sh_bytes[s]} + {1'b0, sh_bytes[b]};
                    if ({1'b0, r.nbytes} > sum2)
                        st = ST_REJECT;
                    else
                    begin
                        sh_used = sh_used - 48'(sum2 - {1'b0, r.nbytes});
                        sh_bytes[s] = r.nbytes;
                        sh_valid[b] = 1'b0;
                    end
                end
            end
            OP_REL_TASK:
            begin
                for (int i = 0; i < NSLOT; i++)
                    if (sh_valid[i] && sh_task[i] == r.tsk)
                    begin
                        if (sh_resv[i]) sh_reserved -= sh_bytes[i];
                        else sh_used -= sh_bytes[i];
                        sh_valid[i] = 1'b0;
                        cnt++;
                    end
            end
            default:
            begin
                if (find_entry(r.h) < 0)
                    st = ST_REJECT;
            end
        endcase
        tally = (r.op == OP_REL_TASK) ? cnt : sh_fails;
        if (r.op == OP_COMMIT || r.op == OP_LOOKUP)
        begin
            s = find_entry(r.h);
            if (s >= 0)
            begin
                e_task = sh_task[s]; e_kind = sh_kind[s];
                e_bytes = sh_bytes[s]; e_resv = sh_resv[s];
            end
        end
        return {2'b00, sh_pk_total, sh_pk_resv, sh_pk_used, sh_reserved, sh_used,
                e_resv, e_bytes, e_kind, e_task, tally, newh, st};
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %0s: got %0h want %0h (result %0d)", what, got, want, n_results);
        errors++;
    endtask

    // driver: bursts and gaps, predicts on acceptance
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            result_q.push_back(account_step(cur_req));
        if (!s_axis_tvalid || s_axis_tready)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pend_q.size() > 0 && rst_n)
            begin
                cur_req = pend_q.pop_front();
                s_axis_tdata <= {3'b000, cur_req.h2, cur_req.h, cur_req.nbytes,
                                 cur_req.knd, cur_req.tsk, cur_req.op};
                s_axis_tvalid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // monitor: own stall pattern, one long hold-off
    int hold_left = 0;
    bit held_once = 0;
    always @(posedge clk)
    begin
        logic [OUT_W-1:0] want;
        logic [OUT_W-1:0] diff;
        if (m_axis_tvalid && m_axis_tready)
        begin
            n_results++;
            if (result_q.size() == 0)
                report_mismatch("unexpected result", m_axis_tdata[63:0], 64'd0);
            else
            begin
                want = result_q.pop_front();
                diff = want ^ m_axis_tdata;
                for (int f = 0; f < 12; f++)
                    if (((diff >> FLD_LO[f]) & ((OUT_W'(1) << FLD_W[f]) - 1)) != 0)
                        report_mismatch(fld_name[f],
                            64'((m_axis_tdata >> FLD_LO[f]) & ((OUT_W'(1) << FLD_W[f]) - 1)),
                            64'((want >> FLD_LO[f]) & ((OUT_W'(1) << FLD_W[f]) - 1)));
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!held_once && n_results >= 400)
        begin
            held_once = 1;
            hold_left = 3000;
            m_axis_tready <= 1'b0;
        end
        else if ((n_results / 50) % 3 == 0)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send(acct_req_t r);
        pend_q.push_back(r);
        while (pend_q.size() > 2)
            @(posedge clk);
    endtask

    task automatic set_capacity(logic [47:0] cap);
        while (pend_q.size() > 0 || s_axis_tvalid || result_q.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= cap;
        sh_cap = cap;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic acct_req_t make_req(opcode_t op, logic [31:0] tsk, logic [1:0] knd,
                                           logic [47:0] nb, logic [31:0] h, logic [31:0] h2);
        acct_req_t r;
        r.op = op; r.tsk = tsk; r.knd = knd; r.nbytes = nb; r.h = h; r.h2 = h2;
        return r;
    endfunction

    function automatic logic [31:0] pick_handle();
        int s;
        if ($urandom_range(0, 9) < 8)
            for (int t = 0; t < 24; t++)
            begin
                s = $urandom_range(0, NSLOT - 1);
                if (sh_valid[s])
                    return sh_handle[s];
            end
        return ($urandom_range(0, 1) != 0) ? $urandom : 32'($urandom_range(0, 3));
    endfunction

    function automatic acct_req_t rand_req(int hold_bias);
        acct_req_t r;
        int        p, s, b;
        p = $urandom_range(0, 99);
        r.op = (p < 30) ? OP_ALLOC : (p < 50) ? OP_RESERVE : (p < 62) ? OP_COMMIT :
               (p < 70 + hold_bias) ? OP_MERGE : (p < 80) ? OP_REL_RES :
               (p < 90) ? OP_RELEASE : (p < 96 - hold_bias) ? OP_REL_TASK : OP_ALLOC;
        p = $urandom_range(0, 99);
        r.tsk = (p < 90) ? 32'($urandom_range(1, 4)) : (p < 95) ? 32'd0 : $urandom;
        r.knd = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 19) == 0)
            r.nbytes = 48'({$urandom, $urandom} & BMAX);
        else
            r.nbytes = 48'({$urandom, $urandom} % (64'(sh_cap) / 16 + 2));
        r.h = pick_handle();
        r.h2 = pick_handle();
        if (r.op == OP_MERGE && $urandom_range(0, 3) != 0)
            for (int t = 0; t < 32; t++)
            begin
                s = $urandom_range(0, NSLOT - 1);
                b = $urandom_range(0, NSLOT - 1);
                if (s != b && sh_valid[s] && sh_valid[b] && !sh_resv[s] && !sh_resv[b] &&
                    sh_kind[s] == KIND_STATE && sh_task[s] == sh_task[b] &&
                    (sh_kind[b] == KIND_BATCH || sh_kind[b] == KIND_INIT))
                begin
                    r.h = sh_handle[s];
                    r.h2 = sh_handle[b];
                    r.nbytes = 48'(({$urandom, $urandom} %
                        (64'(sh_bytes[s]) + 64'(sh_bytes[b]) + 2)));
                    break;
                end
            end
        return r;
    endfunction

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pool: zero-byte insert fits, anything else does not
        set_capacity('0);
        send(make_req(OP_ALLOC, 32'd1, 2'd0, 48'd0, 32'd0, 32'd0));
        send(make_req(OP_RESERVE, 32'hFFFF_FFFF, 2'd3, 48'd1, 32'd0, 32'd0));
        send(make_req(OP_ALLOC, 32'd0, 2'd1, 48'd5, 32'd0, 32'd0));
        send(make_req(OP_REL_TASK, 32'd0, 2'd0, 48'd0, 32'd0, 32'd0));
        send(make_req(OP_RELEASE, 32'd1, 2'd0, 48'd0, 32'hFFFF_FFFF, 32'd0));
        send(make_req(OP_REL_TASK, 32'd1, 2'd0, 48'd0, 32'd0, 32'd0));

        set_capacity(48'd1000);
        send(make_req(OP_ALLOC, 32'd7, 2'd0, 48'd100, 32'd0, 32'd0));     // handle 2
        send(make_req(OP_ALLOC, 32'd7, 2'd1, 48'd50, 32'd0, 32'd0));      // handle 3
        send(make_req(OP_RESERVE, 32'd7, 2'd2, 48'd200, 32'd0, 32'd0));   // handle 4
        send(make_req(OP_COMMIT, 32'd0, 2'd0, 48'd0, 32'd2, 32'd0));      // not a reservation
        send(make_req(OP_COMMIT, 32'd0, 2'd0, 48'd0, 32'd4, 32'd0));
        send(make_req(OP_REL_RES, 32'd0, 2'd0, 48'd0, 32'd4, 32'd0));     // already committed
        send(make_req(OP_MERGE, 32'd0, 2'd0, 48'd151, 32'd2, 32'd3));     // above the sum
        send(make_req(OP_MERGE, 32'd0, 2'd0, 48'd2, 32'd2, 32'd2));       // same handle
        send(make_req(OP_MERGE, 32'd0, 2'd0, 48'd120, 32'd2, 32'd3));
        send(make_req(OP_RESERVE, 32'd8, 2'd0, 48'd300, 32'd0, 32'd0));
        send(make_req(OP_REL_RES, 32'd0, 2'd0, 48'd0, 32'd6, 32'd0));
        send(make_req(OP_RELEASE, 32'd0, 2'd0, 48'd0, 32'd4, 32'd0));
        send(make_req(OP_ALLOC, 32'd8, 2'd0, 48'd2000, 32'd0, 32'd0));    // no space
        send(make_req(OP_REL_TASK, 32'd7, 2'd0, 48'd0, 32'd0, 32'd0));

        // full range, then totals above capacity, then small pools
        set_capacity(BMAX);
        send(make_req(OP_RESERVE, 32'd3, 2'd0, BMAX, 32'd0, 32'd0));
        send(make_req(OP_ALLOC, 32'd3, 2'd0, 48'd1, 32'd0, 32'd0));
        send(make_req(OP_COMMIT, 32'd0, 2'd0, 48'd0, 32'd7, 32'd0));
        set_capacity(48'd10);
        send(make_req(OP_ALLOC, 32'd3, 2'd0, 48'd0, 32'd0, 32'd0));
        send(make_req(OP_REL_TASK, 32'd3, 2'd0, 48'd0, 32'd0, 32'd0));

        set_capacity(BMAX);
        repeat (450) send(rand_req(0));
        set_capacity(48'd5000);
        repeat (500) send(rand_req(6));      // no task releases so the table fills
        set_capacity(48'd1);
        repeat (100) send(rand_req(0));
        set_capacity(48'({$urandom, $urandom} & BMAX));
        repeat (450) send(rand_req(3));
        set_capacity(48'd0);
        repeat (100) send(rand_req(0));
        set_capacity(48'd200000);
        repeat (320) send(rand_req(0));

        while (pend_q.size() > 0 || s_axis_tvalid || result_q.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

@@ filelist.f @@
sv/srat_pkg.sv
sv/storage_reservation_accounting_table.sv
tb/storage_reservation_accounting_table_tb.sv
